### rtl/rlp_pkg.sv
// shared constants and types for the random letter pairing block
// no dependencies; every other file in rtl uses it by scoped names
package rlp_pkg;

    localparam int MAX_LETTERS_DEF = 32;
    localparam int RAND_W          = 31;
    localparam int CFG_W           = 6;
    localparam int POS_W           = 5;
    localparam int PAIR_NUM_W      = 4;
    localparam int PAIRS_W         = 5;
    localparam int EXT_W           = 7;
    localparam int STEP_W          = $clog2(RAND_W);

    localparam logic [CFG_W-1:0] LETTERS_RESET = 6'd26;

    typedef struct packed {
        logic              start;
        logic [RAND_W-1:0] dividend;
    } t_mod_req;

endpackage

### rtl/rlp_in_if.sv
// request channel carrying the two random words of one pair
// depends on rlp_pkg
interface rlp_in_if;
    logic                      valid;
    logic                      ready;
    logic [rlp_pkg::RAND_W-1:0] random_first;
    logic [rlp_pkg::RAND_W-1:0] random_second;

    modport source (output valid, output random_first, output random_second, input ready);
    modport sink   (input valid, input random_first, input random_second, output ready);
endinterface

### rtl/rlp_out_if.sv
// result channel carrying one reported pair and its status
// depends on rlp_pkg
interface rlp_out_if;
    logic                          valid;
    logic                          ready;
    logic [rlp_pkg::POS_W-1:0]      first_position;
    logic [rlp_pkg::POS_W-1:0]      second_position;
    logic [rlp_pkg::PAIR_NUM_W-1:0] pair_number;
    logic                          last_pair;
    logic                          status;

    modport source (output valid, output first_position, output second_position,
                    output pair_number, output last_pair, output status, input ready);
    modport sink   (input valid, input first_position, input second_position,
                    input pair_number, input last_pair, input status, output ready);
endinterface

### rtl/rlp_mod_unit.sv
// iterative remainder unit, one dividend bit per cycle (restoring)
// depends on rlp_pkg
module rlp_mod_unit #(
    parameter int DIV_W = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rlp_pkg::t_mod_req     i_req,
    input  logic [DIV_W-1:0]      i_divisor,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_rem
);

    logic                        r_busy;
    logic                        r_done;
    logic [rlp_pkg::STEP_W-1:0]  r_step;
    logic [rlp_pkg::RAND_W-1:0]  r_dvd;
    logic [DIV_W-1:0]            r_rem;
    logic [DIV_W-1:0]            r_div;

    logic [DIV_W:0]              w_trial;
    logic [DIV_W-1:0]            n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[rlp_pkg::RAND_W-1]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = DIV_W'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = DIV_W'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == rlp_pkg::STEP_W'(rlp_pkg::RAND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### rtl/random_letter_pairing_core.sv
// top level: sequencer that counts, reduces and scans the unpaired mask
// depends on rlp_pkg, rlp_in_if, rlp_out_if, rlp_mod_unit
//
// channel   dir  handshake      payload
// i_in      in   valid/ready    random_first, random_second
// o_out     out  valid/ready    first_position, second_position, pair_number,
//                               last_pair, status
// i_cfg     in   i_cfg_wr_en    i_cfg_wr_data (letter_count)
//
// one request at a time; the work for it is set by the bit-serial mask count
// and two k-th bit scans plus two 31-step remainder passes in the shared
// remainder unit; a bad letter count skips from the check to the result
// reset is synchronous active low and restores a full mask and a count of 26
// the result sits in an output register, so a new request is taken while the
// previous result waits; the sequencer only holds its final step on a stall
module random_letter_pairing_core #(
    parameter int MAX_LETTERS = rlp_pkg::MAX_LETTERS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rlp_in_if.sink                    i_in,
    rlp_out_if.source                 o_out,
    input  logic                      i_cfg_wr_en,
    input  logic [rlp_pkg::CFG_W-1:0] i_cfg_wr_data
);

    localparam int IW = $clog2(MAX_LETTERS);
    localparam int CW = $clog2(MAX_LETTERS + 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CHECK = 8'b0000_0010,
        ST_COUNT = 8'b0000_0100,
        ST_MOD1  = 8'b0000_1000,
        ST_SCAN1 = 8'b0001_0000,
        ST_MOD2  = 8'b0010_0000,
        ST_SCAN2 = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } t_state;

    t_state                        r_state;
    logic [rlp_pkg::CFG_W-1:0]     r_n;
    logic [MAX_LETTERS-1:0]        r_mask;
    logic [rlp_pkg::PAIRS_W-1:0]   r_pairs;
    logic [rlp_pkg::RAND_W-1:0]    r_r1;
    logic [rlp_pkg::RAND_W-1:0]    r_r2;
    logic [CW-1:0]                 r_idx;
    logic [CW-1:0]                 r_cnt;
    logic [CW-1:0]                 r_remain;
    logic [CW-1:0]                 r_k;
    logic [IW-1:0]                 r_p1;
    logic [IW-1:0]                 r_p2;
    logic                          r_err;

    logic                              r_ov;
    logic [rlp_pkg::POS_W-1:0]         r_o_first;
    logic [rlp_pkg::POS_W-1:0]         r_o_second;
    logic [rlp_pkg::PAIR_NUM_W-1:0]    r_o_pair;
    logic                              r_o_last;
    logic                              r_o_status;

    logic [IW-1:0]                 w_idx;
    logic                          w_active;
    logic                          w_idx_end;
    logic                          w_invalid;
    logic                          w_out_free;
    logic                          w_last;
    logic [CW-1:0]                 w_cnt_final;
    logic [CW-1:0]                 w_remain_new;
    logic [rlp_pkg::EXT_W-1:0]     w_p1_ext;
    logic [rlp_pkg::EXT_W-1:0]     w_p2_ext;

    rlp_pkg::t_mod_req             w_mod_req;
    logic [CW-1:0]                 w_mod_div;
    logic                          w_mod_done;
    logic [CW-1:0]                 w_mod_rem;

    always_comb begin
        w_idx        = r_idx[IW-1:0];
        w_active     = r_mask[w_idx]
                       && (rlp_pkg::EXT_W'(r_idx) < rlp_pkg::EXT_W'(r_n));
        w_idx_end    = (r_idx == CW'(MAX_LETTERS - 1));
        w_invalid    = r_n[0] || (r_n == '0)
                       || (rlp_pkg::EXT_W'(r_n) > rlp_pkg::EXT_W'(MAX_LETTERS));
        w_out_free   = !r_ov || o_out.ready;
        w_last       = (r_remain == CW'(2));
        w_cnt_final  = r_cnt + CW'(w_active);
        w_remain_new = (w_cnt_final < CW'(2)) ? CW'(r_n) : w_cnt_final;
        w_p1_ext     = rlp_pkg::EXT_W'(r_p1);
        w_p2_ext     = rlp_pkg::EXT_W'(r_p2);

        w_mod_req.start    = 1'b0;
        w_mod_req.dividend = r_r2;
        w_mod_div          = r_remain - 1'b1;
        unique case (r_state)
            ST_COUNT: begin
                w_mod_req.start    = w_idx_end;
                w_mod_req.dividend = r_r1;
                w_mod_div          = w_remain_new;
            end
            ST_SCAN1: begin
                w_mod_req.start = w_active && (r_k == '0);
            end
            default: begin
            end
        endcase
    end

    rlp_mod_unit #(
        .DIV_W (CW)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mod_req),
        .i_divisor (w_mod_div),
        .o_done    (w_mod_done),
        .o_rem     (w_mod_rem)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= rlp_pkg::LETTERS_RESET;
            r_mask  <= '1;
            r_pairs <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_n <= i_cfg_wr_data;
            end
            if (o_out.ready && (r_state != ST_DONE)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_state <= w_invalid ? ST_DONE : ST_COUNT;
                end
                ST_COUNT: begin
                    if (w_idx_end) begin
                        r_state <= ST_MOD1;
                        if (w_cnt_final < CW'(2)) begin
                            r_mask  <= '1;
                            r_pairs <= '0;
                        end
                    end
                end
                ST_MOD1: begin
                    if (w_mod_done) begin
                        r_state <= ST_SCAN1;
                    end
                end
                ST_SCAN1: begin
                    if (w_mod_req.start) begin
                        r_state <= ST_MOD2;
                    end
                end
                ST_MOD2: begin
                    if (w_mod_done) begin
                        r_state <= ST_SCAN2;
                    end
                end
                ST_SCAN2: begin
                    if (w_active && (w_idx != r_p1) && (r_k == '0)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                        r_ov    <= 1'b1;
                        if (!r_err) begin
                            if (w_last) begin
                                r_mask  <= '1;
                                r_pairs <= '0;
                            end else begin
                                r_mask  <= r_mask & ~(MAX_LETTERS'(1) << r_p1)
                                           & ~(MAX_LETTERS'(1) << r_p2);
                                r_pairs <= r_pairs + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_r1 <= i_in.random_first;
                r_r2 <= i_in.random_second;
            end
            ST_CHECK: begin
                r_err <= w_invalid;
                r_idx <= '0;
                r_cnt <= '0;
            end
            ST_COUNT: begin
                r_idx    <= r_idx + 1'b1;
                r_cnt    <= w_cnt_final;
                r_remain <= w_remain_new;
            end
            ST_MOD1, ST_MOD2: begin
                r_k   <= w_mod_rem;
                r_idx <= '0;
            end
            ST_SCAN1: begin
                r_idx <= r_idx + 1'b1;
                if (w_active) begin
                    r_k  <= r_k - 1'b1;
                    r_p1 <= w_idx;
                end
            end
            ST_SCAN2: begin
                r_idx <= r_idx + 1'b1;
                if (w_active && (w_idx != r_p1)) begin
                    r_k  <= r_k - 1'b1;
                    r_p2 <= w_idx;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    if (r_err) begin
                        r_o_first  <= '0;
                        r_o_second <= '0;
                        r_o_pair   <= '0;
                        r_o_last   <= 1'b0;
                        r_o_status <= 1'b1;
                    end else begin
                        r_o_first  <= w_p1_ext[rlp_pkg::POS_W-1:0];
                        r_o_second <= w_p2_ext[rlp_pkg::POS_W-1:0];
                        r_o_pair   <= r_pairs[rlp_pkg::PAIR_NUM_W-1:0];
                        r_o_last   <= w_last;
                        r_o_status <= 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready            = (r_state == ST_IDLE);
    assign o_out.valid           = r_ov;
    assign o_out.first_position  = r_o_first;
    assign o_out.second_position = r_o_second;
    assign o_out.pair_number     = r_o_pair;
    assign o_out.last_pair       = r_o_last;
    assign o_out.status          = r_o_status;

endmodule

### rtl/rlp_checker.sv
// port level checks for random_letter_pairing_core, attached by bind
// depends on rlp_pkg and the ports of random_letter_pairing_core
module rlp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [rlp_pkg::POS_W-1:0]      i_first,
    input logic [rlp_pkg::POS_W-1:0]      i_second,
    input logic [rlp_pkg::PAIR_NUM_W-1:0] i_pair,
    input logic                           i_last,
    input logic                           i_status
);

    // a stalled result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
        && $stable(i_first) && $stable(i_second) && $stable(i_pair)
        && $stable(i_last) && $stable(i_status))
        else $error("result changed while stalled");

    // one request in flight
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");

    // error results carry no pair
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> i_first == '0 && i_second == '0
        && i_pair == '0 && !i_last)
        else $error("error result with pair fields set");

    // a good pair joins two distinct positions
    a_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_status |-> i_first != i_second)
        else $error("pair joins a position to itself");

endmodule

bind random_letter_pairing_core rlp_checker u_rlp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_first     (o_out.first_position),
    .i_second    (o_out.second_position),
    .i_pair      (o_out.pair_number),
    .i_last      (o_out.last_pair),
    .i_status    (o_out.status)
);
